/* hdl/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants of the reliable datagram connection engine.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int FUT_SLOTS  = 8;
    localparam int PEND_SLOTS = 8;
    localparam int FUT_AW     = (FUT_SLOTS > 1) ? $clog2(FUT_SLOTS) : 1;
    localparam int PEND_AW    = (PEND_SLOTS > 1) ? $clog2(PEND_SLOTS) : 1;
    localparam int FUT_CW     = $clog2(FUT_SLOTS + 1);
    localparam int PEND_CW    = $clog2(PEND_SLOTS + 1);
    localparam int IDX_W      = (FUT_CW > PEND_CW) ? FUT_CW : PEND_CW;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_PKT   = 2'd1;
    localparam logic [1:0] OP_TRACK = 2'd2;
    localparam logic [1:0] OP_CLOSE = 2'd3;

    localparam logic [2:0] PT_ACK = 3'd0;
    localparam logic [2:0] PT_REJ = 3'd1;
    localparam logic [2:0] PT_ORD = 3'd2;
    localparam logic [2:0] PT_UNR = 3'd3;

    localparam logic [2:0] ACT_DELIVER = 3'd0;
    localparam logic [2:0] ACT_ACK     = 3'd1;
    localparam logic [2:0] ACT_RESEND  = 3'd2;
    localparam logic [2:0] ACT_KEEP    = 3'd3;
    localparam logic [2:0] ACT_RELEASE = 3'd4;
    localparam logic [2:0] ACT_STATUS  = 3'd5;

    localparam logic [2:0] LS_CONN    = 3'd0;
    localparam logic [2:0] LS_CLOSING = 3'd1;
    localparam logic [2:0] LS_CLOSED  = 3'd2;
    localparam logic [2:0] LS_TIMEOUT = 3'd3;
    localparam logic [2:0] LS_REJ     = 3'd4;

    localparam logic [1:0] CFG_RTO  = 2'd0;
    localparam logic [1:0] CFG_KA   = 2'd1;
    localparam logic [1:0] CFG_RXTO = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] time_now;
        logic [2:0]  packet_type;
        logic [31:0] sequence_number;
        logic [7:0]  message_id;
        logic [7:0]  buffer_tag;
        logic [15:0] payload_length;
    } req_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] out_sequence;
        logic [7:0]  out_message_id;
        logic [7:0]  out_buffer_tag;
        logic [15:0] out_length;
        logic [2:0]  connection_state;
        logic        store_full;
        logic        last_result;
    } rsp_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [7:0]  mid;
        logic [7:0]  tag;
        logic [15:0] len;
    } fut_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [7:0]  tag;
        logic [15:0] len;
        logic [31:0] sent;
    } pend_t;

endpackage

/* hdl/reliable_datagram_connection_top.sv */
// ----------------------------------------------------------------------------
// reliable_datagram_connection_top
// Connection engine: ack/resend tracking and ordered delivery of datagrams.
// ----------------------------------------------------------------------------
// One word is taken at a time. Close and track each end in a status
// word; an arriving packet is sorted by type, and an ack searches the
// pending store entry by entry. A tick walks the future store and then
// the pending store, since each store has one read port and entries
// are visited one per read. Stalls on the result side hold the engine.
module reliable_datagram_connection_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rdc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rdc_pkg::rsp_t rsp,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic [31:0]   cfg_data
);

    import rdc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_PKT, S_ACK, S_DLV, S_REL, S_STATUS, S_TRACK, S_CLOSE,
        S_A_RD, S_A_EV, S_M_RD, S_M_EV, S_F_RD, S_F_EV, S_P_RD, S_P_EV, S_KA
    } state_t;

    state_t             state_reg, state_next;
    req_t               item_reg, item_next;
    rsp_t               rsp_reg;
    logic               rsp_valid_reg;
    logic [31:0]        rto_reg, ka_reg, rxto_reg;
    logic [31:0]        exp_reg, exp_next;
    logic [31:0]        lst_reg, lst_next;
    logic [31:0]        lrt_reg, lrt_next;
    logic [2:0]         link_reg, link_next;
    logic [FUT_CW-1:0]  fcnt_reg, fcnt_next;
    logic [PEND_CW-1:0] pcnt_reg, pcnt_next;
    logic [IDX_W-1:0]   rd_reg, rd_next, wr_reg, wr_next, rd_inc;
    logic               full_reg, full_next;

    logic               emit_en, out_free;
    rsp_t               emit_d;
    logic [2:0]         nl;

    logic               fut_rd_en, fut_we;
    logic [FUT_AW-1:0]  fut_rd_addr, fut_wr_addr;
    fut_t               fut_q, fut_wd;
    logic               pend_rd_en, pend_we;
    logic [PEND_AW-1:0] pend_rd_addr, pend_wr_addr;
    pend_t              pend_q, pend_wd;

    rdc_ram #(.WIDTH($bits(fut_t)), .DEPTH(FUT_SLOTS)) u_fut (
        .clk     (clk),
        .rd_en   (fut_rd_en),
        .rd_addr (fut_rd_addr),
        .rd_data (fut_q),
        .wr_en   (fut_we),
        .wr_addr (fut_wr_addr),
        .wr_data (fut_wd)
    );

    rdc_ram #(.WIDTH($bits(pend_t)), .DEPTH(PEND_SLOTS)) u_pend (
        .clk     (clk),
        .rd_en   (pend_rd_en),
        .rd_addr (pend_rd_addr),
        .rd_data (pend_q),
        .wr_en   (pend_we),
        .wr_addr (pend_wr_addr),
        .wr_data (pend_wd)
    );

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rd_inc    = rd_reg + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        exp_next     = exp_reg;
        lst_next     = lst_reg;
        lrt_next     = lrt_reg;
        link_next    = link_reg;
        fcnt_next    = fcnt_reg;
        pcnt_next    = pcnt_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        full_next    = full_reg;
        emit_en      = 1'b0;
        emit_d       = '0;
        emit_d.connection_state = link_reg;
        nl           = link_reg;
        fut_rd_en    = 1'b0;
        fut_rd_addr  = rd_reg[FUT_AW-1:0];
        fut_we       = 1'b0;
        fut_wr_addr  = wr_reg[FUT_AW-1:0];
        fut_wd       = fut_q;
        pend_rd_en   = 1'b0;
        pend_rd_addr = rd_reg[PEND_AW-1:0];
        pend_we      = 1'b0;
        pend_wr_addr = rd_reg[PEND_AW-1:0];
        pend_wd      = pend_q;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    full_next = 1'b0;
                    rd_next   = '0;
                    wr_next   = '0;
                    unique case (req.opcode)
                        OP_TICK:  state_next = S_F_RD;
                        OP_PKT:   state_next = S_PKT;
                        OP_TRACK: state_next = S_TRACK;
                        default:  state_next = S_CLOSE;
                    endcase
                end
            end
            S_PKT:
            begin
                lrt_next = item_reg.time_now;
                unique case (item_reg.packet_type)
                    PT_ACK: state_next = S_A_RD;
                    PT_REJ:
                    begin
                        link_next  = LS_REJ;
                        state_next = S_REL;
                    end
                    PT_ORD:  state_next = S_ACK;
                    PT_UNR:  state_next = S_DLV;
                    default: state_next = S_REL;
                endcase
            end
            S_ACK:
            begin
                emit_en             = 1'b1;
                emit_d.action       = ACT_ACK;
                emit_d.out_sequence = item_reg.sequence_number;
                if (out_free)
                begin
                    if (item_reg.sequence_number < exp_reg)
                    begin
                        state_next = S_REL;
                    end
                    else if (item_reg.sequence_number > exp_reg)
                    begin
                        if (fcnt_reg < FUT_CW'(FUT_SLOTS))
                        begin
                            fut_we      = 1'b1;
                            fut_wr_addr = fcnt_reg[FUT_AW-1:0];
                            fut_wd      = '{seq: item_reg.sequence_number,
                                            mid: item_reg.message_id,
                                            tag: item_reg.buffer_tag,
                                            len: item_reg.payload_length};
                            fcnt_next   = fcnt_reg + 1'b1;
                            state_next  = S_STATUS;
                        end
                        else
                        begin
                            full_next  = 1'b1;
                            state_next = S_REL;
                        end
                    end
                    else
                    begin
                        exp_next   = exp_reg + 1'b1;
                        state_next = S_DLV;
                    end
                end
            end
            S_DLV:
            begin
                emit_en               = 1'b1;
                emit_d.action         = ACT_DELIVER;
                emit_d.out_sequence   = item_reg.sequence_number;
                emit_d.out_message_id = item_reg.message_id;
                emit_d.out_buffer_tag = item_reg.buffer_tag;
                emit_d.out_length     = item_reg.payload_length;
                if (out_free)
                begin
                    state_next = S_STATUS;
                end
            end
            S_REL:
            begin
                emit_en               = 1'b1;
                emit_d.action         = ACT_RELEASE;
                emit_d.out_buffer_tag = item_reg.buffer_tag;
                emit_d.store_full     = full_reg;
                if (out_free)
                begin
                    state_next = S_STATUS;
                end
            end
            S_STATUS:
            begin
                emit_en            = 1'b1;
                emit_d.action      = ACT_STATUS;
                emit_d.store_full  = full_reg;
                emit_d.last_result = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TRACK:
            begin
                lst_next = item_reg.time_now;
                if (pcnt_reg < PEND_CW'(PEND_SLOTS))
                begin
                    pend_we      = 1'b1;
                    pend_wr_addr = pcnt_reg[PEND_AW-1:0];
                    pend_wd      = '{seq:  item_reg.sequence_number,
                                     tag:  item_reg.buffer_tag,
                                     len:  item_reg.payload_length,
                                     sent: item_reg.time_now};
                    pcnt_next    = pcnt_reg + 1'b1;
                    state_next   = S_STATUS;
                end
                else
                begin
                    full_next  = 1'b1;
                    state_next = S_REL;
                end
            end
            S_CLOSE:
            begin
                if (link_reg == LS_CONN)
                begin
                    link_next = LS_CLOSING;
                end
                state_next = S_STATUS;
            end
            S_A_RD:
            begin
                if (rd_reg < IDX_W'(pcnt_reg))
                begin
                    pend_rd_en = 1'b1;
                    state_next = S_A_EV;
                end
                else
                begin
                    state_next = S_REL;
                end
            end
            S_A_EV:
            begin
                if (pend_q.seq == item_reg.sequence_number)
                begin
                    emit_en               = 1'b1;
                    emit_d.action         = ACT_RELEASE;
                    emit_d.out_buffer_tag = pend_q.tag;
                    if (out_free)
                    begin
                        state_next = S_M_RD;
                    end
                end
                else
                begin
                    rd_next    = rd_inc;
                    state_next = S_A_RD;
                end
            end
            // close the gap left by the acked entry
            S_M_RD:
            begin
                if (rd_inc < IDX_W'(pcnt_reg))
                begin
                    pend_rd_en   = 1'b1;
                    pend_rd_addr = rd_inc[PEND_AW-1:0];
                    state_next   = S_M_EV;
                end
                else
                begin
                    pcnt_next  = pcnt_reg - 1'b1;
                    state_next = S_REL;
                end
            end
            S_M_EV:
            begin
                pend_we    = 1'b1;
                rd_next    = rd_inc;
                state_next = S_M_RD;
            end
            S_F_RD:
            begin
                if (rd_reg < IDX_W'(fcnt_reg))
                begin
                    fut_rd_en  = 1'b1;
                    state_next = S_F_EV;
                end
                else
                begin
                    fcnt_next  = wr_reg[FUT_CW-1:0];
                    rd_next    = '0;
                    state_next = S_P_RD;
                end
            end
            S_F_EV:
            begin
                if (fut_q.seq == exp_reg)
                begin
                    emit_en               = 1'b1;
                    emit_d.action         = ACT_DELIVER;
                    emit_d.out_sequence   = fut_q.seq;
                    emit_d.out_message_id = fut_q.mid;
                    emit_d.out_buffer_tag = fut_q.tag;
                    emit_d.out_length     = fut_q.len;
                    if (out_free)
                    begin
                        exp_next   = exp_reg + 1'b1;
                        rd_next    = rd_inc;
                        state_next = S_F_RD;
                    end
                end
                else if (fut_q.seq < exp_reg)
                begin
                    emit_en               = 1'b1;
                    emit_d.action         = ACT_RELEASE;
                    emit_d.out_buffer_tag = fut_q.tag;
                    if (out_free)
                    begin
                        rd_next    = rd_inc;
                        state_next = S_F_RD;
                    end
                end
                else
                begin
                    fut_we     = 1'b1;
                    wr_next    = wr_reg + 1'b1;
                    rd_next    = rd_inc;
                    state_next = S_F_RD;
                end
            end
            S_P_RD:
            begin
                if (rd_reg < IDX_W'(pcnt_reg))
                begin
                    pend_rd_en = 1'b1;
                    state_next = S_P_EV;
                end
                else
                begin
                    state_next = S_KA;
                end
            end
            S_P_EV:
            begin
                if ((item_reg.time_now - pend_q.sent) >= rto_reg)
                begin
                    emit_en               = 1'b1;
                    emit_d.action         = ACT_RESEND;
                    emit_d.out_sequence   = pend_q.seq;
                    emit_d.out_buffer_tag = pend_q.tag;
                    emit_d.out_length     = pend_q.len;
                    if (out_free)
                    begin
                        pend_we      = 1'b1;
                        pend_wd.sent = item_reg.time_now;
                        rd_next      = rd_inc;
                        state_next   = S_P_RD;
                    end
                end
                else
                begin
                    rd_next    = rd_inc;
                    state_next = S_P_RD;
                end
            end
            S_KA:
            begin
                if ((item_reg.time_now - lrt_reg) >= rxto_reg)
                begin
                    nl = LS_TIMEOUT;
                end
                if (pcnt_reg == '0 && nl == LS_CLOSING)
                begin
                    nl = LS_CLOSED;
                end
                if ((item_reg.time_now - lst_reg) >= ka_reg)
                begin
                    emit_en       = 1'b1;
                    emit_d.action = ACT_KEEP;
                    if (out_free)
                    begin
                        lst_next   = item_reg.time_now;
                        link_next  = nl;
                        state_next = S_STATUS;
                    end
                end
                else
                begin
                    link_next  = nl;
                    state_next = S_STATUS;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rto_reg       <= 32'd1;
            ka_reg        <= 32'd2;
            rxto_reg      <= 32'd10;
            exp_reg       <= '0;
            lst_reg       <= '0;
            lrt_reg       <= '0;
            link_reg      <= LS_CONN;
            fcnt_reg      <= '0;
            pcnt_reg      <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            full_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            exp_reg   <= exp_next;
            lst_reg   <= lst_next;
            lrt_reg   <= lrt_next;
            link_reg  <= link_next;
            fcnt_reg  <= fcnt_next;
            pcnt_reg  <= pcnt_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            full_reg  <= full_next;
            if (emit_en && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_RTO:  rto_reg  <= cfg_data;
                    CFG_KA:   ka_reg   <= cfg_data;
                    CFG_RXTO: rxto_reg <= cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (emit_en && out_free)
        begin
            rsp_reg <= emit_d;
        end
    end

endmodule

/* hdl/rdc_ram.sv */
// ----------------------------------------------------------------------------
// rdc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rdc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                       clk,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
